// ===== design/grfi_pkg.sv =====
// Shared types and constants of the gyro rate filter and integrator.
`timescale 1ns / 1ps
`default_nettype none
package grfi_pkg;

  localparam int unsigned NumAxes   = 2;
  localparam int unsigned WSample   = 10;
  localparam int unsigned WElapsed  = 10;
  localparam int unsigned WWeight   = 9;
  localparam int unsigned WSettle   = 10;
  localparam int unsigned WBias     = 14;
  localparam int unsigned WDiff     = 16;
  localparam int unsigned WFilt     = 24;
  localparam int unsigned WQuiet    = 11;
  localparam int unsigned WStep     = 27;
  localparam int unsigned WScaled   = 34;
  localparam int unsigned WQuot     = 28;
  localparam int unsigned RecipShift = 34;
  localparam int unsigned WProd     = 62;
  localparam int unsigned DivSteps  = 1;
  localparam int unsigned WDivCnt   = 1;

  // Angle step scale: 2.44 * pi * 2^20 / (2560 * 1000 * 180) as an exact fraction.
  localparam logic [25:0] STEP_NUM = 26'd38327398;
  localparam logic [31:0] STEP_DEN = 32'd2197265625;
  localparam logic [30:0] HALF_DEN = 31'd1098632812;

  // Floors of STEP_NUM * 2^34 / STEP_DEN and HALF_DEN * 2^34 / STEP_DEN.
  localparam logic [28:0] RECIP      = 29'd299672318;
  localparam logic [33:0] RECIP_BIAS = 34'd8589934588;

  localparam logic [WBias-1:0]    ZERO_RESET   = 14'd2580;
  localparam logic [WWeight-1:0]  WEIGHT_RESET = 9'd154;
  localparam logic [WWeight-1:0]  WEIGHT_FULL  = 9'd256;
  localparam logic [WSettle-1:0]  SETTLE_RESET = 10'd100;
  localparam logic [WQuiet-1:0]   QUIET_MAX    = 11'd2047;

  localparam logic REG_FILTER_WEIGHT = 1'b0;
  localparam logic REG_SETTLE_MS     = 1'b1;

  typedef struct packed {
    logic load;      // capture the incoming item
    logic cal_mul;   // calibration update and filter products
    logic acc;       // filter accumulate and round
    logic scale;     // magnitude times elapsed time
    logic num;       // reciprocal estimate of the quotient
    logic div_step;  // remainder check per lane
    logic out_load;  // move the result into the output register
  } grfi_cmd_t;

  typedef struct packed {
    logic div_last;
  } grfi_sts_t;

endpackage
`default_nettype wire

// ===== design/grfi_div_lane.sv =====
// Division by the constant step denominator: reciprocal estimate, then one remainder check.
`timescale 1ns / 1ps
`default_nettype none
module grfi_div_lane (
  input  wire logic                          clk_i,
  input  wire logic                          load_i,
  input  wire logic                          step_i,
  input  wire logic [grfi_pkg::WScaled-1:0]  scaled_i,
  output logic      [grfi_pkg::WQuot-1:0]    quot_o
);
  import grfi_pkg::*;

  logic [WScaled-1:0] num_low;
  logic [WProd-1:0]   est_full;
  logic [WScaled-1:0] num_low_q;
  logic [WQuot-1:0]   est_q;
  logic [WScaled-1:0] rem_q, rem_d;

  // The estimate is the rounded quotient or one below it, so the remainder
  // stays below twice the denominator and the low numerator bits suffice.
  assign num_low  = scaled_i * WScaled'(STEP_NUM) + WScaled'(HALF_DEN);
  assign est_full = WProd'(scaled_i) * WProd'(RECIP) + WProd'(RECIP_BIAS);
  assign rem_d    = num_low_q - WScaled'(est_q) * WScaled'(STEP_DEN);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_low_q <= num_low;
      est_q     <= est_full[WProd-1:RecipShift];
    end else if (step_i) begin
      rem_q <= rem_d;
    end
  end

  assign quot_o = est_q + WQuot'(rem_q >= WScaled'(STEP_DEN));

endmodule
`default_nettype wire

// ===== design/grfi_datapath.sv =====
// Datapath: bias calibration, IIR filter, step scaling and output register.
`timescale 1ns / 1ps
`default_nettype none
module grfi_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire grfi_pkg::grfi_cmd_t           cmd_i,
  output grfi_pkg::grfi_sts_t                sts_o,
  input  wire logic [grfi_pkg::WWeight-1:0]  filter_weight_i,
  input  wire logic [grfi_pkg::WSettle-1:0]  settle_ms_i,
  input  wire logic [grfi_pkg::WSample-1:0]  pitch_sample_i,
  input  wire logic [grfi_pkg::WSample-1:0]  roll_sample_i,
  input  wire logic [grfi_pkg::WElapsed-1:0] elapsed_ms_i,
  input  wire logic                          begin_calibration_i,
  output logic      [grfi_pkg::WStep-1:0]    pitch_step_o,
  output logic      [grfi_pkg::WStep-1:0]    roll_step_o,
  output logic      [grfi_pkg::WBias-1:0]    pitch_bias_o,
  output logic      [grfi_pkg::WBias-1:0]    roll_bias_o,
  output logic                               calibrating_o
);
  import grfi_pkg::*;

  // Captured item
  logic [WSample-1:0]  sample_q [NumAxes];
  logic [WElapsed-1:0] el_q;
  logic                begin_q;

  // Persistent state
  logic signed [WFilt-1:0] filt_q [NumAxes];
  logic [WBias-1:0]        zero_q [NumAxes];
  logic [WBias-1:0]        zero_d [NumAxes];
  logic [WQuiet-1:0]       quiet_q [NumAxes];
  logic [WQuiet-1:0]       quiet_d [NumAxes];
  logic                    settled_q [NumAxes];
  logic                    settled_d [NumAxes];
  logic                    cal_q, cal_d;

  // Working registers
  logic signed [25:0]       p_new_q [NumAxes];
  logic signed [WScaled-1:0] p_old_q [NumAxes];
  logic [WScaled-1:0]       scaled_q [NumAxes];
  logic                     neg_q [NumAxes];
  logic [WDivCnt-1:0]       cnt_q;
  logic [WStep-1:0]         step_q [NumAxes];
  logic [WBias-1:0]         bias_q [NumAxes];
  logic                     cal_out_q;

  // Combinational
  logic [WBias-1:0]         times10 [NumAxes];
  logic signed [WDiff-1:0]  diff [NumAxes];
  logic                     s_eff [NumAxes];
  logic [WQuiet-1:0]        q_eff [NumAxes];
  logic [WQuiet:0]          q_sum [NumAxes];
  logic [WQuiet-1:0]        q_new [NumAxes];
  logic                     cal_eff;
  logic [WWeight-1:0]       w_eff, w_rest;
  logic signed [34:0]       acc [NumAxes];
  logic [34:0]              acc_mag [NumAxes];
  logic [34:0]              acc_rnd [NumAxes];
  logic signed [WFilt-1:0]  filt_d [NumAxes];
  logic [WFilt-1:0]         f_mag [NumAxes];
  logic [WQuot-1:0]         quot [NumAxes];
  logic [WStep-1:0]         step_d [NumAxes];

  assign w_eff  = (filter_weight_i > WEIGHT_FULL) ? WEIGHT_FULL : filter_weight_i;
  assign w_rest = WEIGHT_FULL - w_eff;
  assign cal_eff = cal_q | begin_q;

  // Calibration: a start clears the settled flags and quiet times; an
  // unsettled axis walks its bias one tenth toward the reading.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      times10[a] = WBias'(sample_q[a]) * WBias'(10);
      diff[a]    = $signed({2'b00, times10[a]}) - $signed({2'b00, zero_q[a]});
      s_eff[a]   = begin_q ? 1'b0 : settled_q[a];
      q_eff[a]   = begin_q ? '0 : quiet_q[a];
      q_sum[a]   = {1'b0, q_eff[a]} + (WQuiet+1)'(el_q);
      if (begin_q) begin
        q_new[a] = q_eff[a];
      end else if (q_sum[a] > {1'b0, QUIET_MAX}) begin
        q_new[a] = QUIET_MAX;
      end else begin
        q_new[a] = q_sum[a][WQuiet-1:0];
      end
      zero_d[a]    = zero_q[a];
      quiet_d[a]   = q_eff[a];
      settled_d[a] = s_eff[a];
      if (cal_eff && !s_eff[a]) begin
        if (diff[a] > 0) begin
          zero_d[a]  = zero_q[a] + 1'b1;
          quiet_d[a] = '0;
        end else if (diff[a] < 0) begin
          zero_d[a]  = zero_q[a] - 1'b1;
          quiet_d[a] = '0;
        end else begin
          quiet_d[a] = q_new[a];
          if (q_new[a] >= {1'b0, settle_ms_i}) begin
            settled_d[a] = 1'b1;
          end
        end
      end
    end
    cal_d = cal_eff && !(settled_d[0] && settled_d[1]);
  end

  // Filter: acc = w*diff*256 + (256-w)*old, divided by 256 rounding half
  // away from zero, clamped to the state width.
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      acc[a]     = $signed({p_new_q[a][25], p_new_q[a], 8'h00})
                 + $signed({p_old_q[a][WScaled-1], p_old_q[a]});
      acc_mag[a] = acc[a][34] ? 35'(-acc[a]) : 35'(acc[a]);
      acc_rnd[a] = acc_mag[a] + 35'd128;
      if (!acc[a][34] && (acc_rnd[a][34:8] > 27'd8388607)) begin
        filt_d[a] = 24'sh7FFFFF;
      end else if (acc[a][34] && (acc_rnd[a][34:8] > 27'd8388608)) begin
        filt_d[a] = 24'sh800000;
      end else if (acc[a][34]) begin
        filt_d[a] = WFilt'(-$signed({1'b0, acc_rnd[a][34:8]}));
      end else begin
        filt_d[a] = $signed(acc_rnd[a][WFilt+7:8]);
      end
      f_mag[a] = filt_q[a][WFilt-1] ? WFilt'(-filt_q[a]) : WFilt'(filt_q[a]);
      if (!neg_q[a]) begin
        step_d[a] = (quot[a] > 28'd67108863) ? 27'h3FFFFFF : quot[a][WStep-1:0];
      end else begin
        step_d[a] = (quot[a] > 28'd67108864) ? 27'h4000000
                                             : WStep'(-quot[a][WStep-1:0]);
      end
    end
  end

  for (genvar g = 0; g < NumAxes; g++) begin : g_div
    grfi_div_lane u_div (
      .clk_i    (clk_i),
      .load_i   (cmd_i.num),
      .step_i   (cmd_i.div_step),
      .scaled_i (scaled_q[g]),
      .quot_o   (quot[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= 1'b0;
      cnt_q <= '0;
      for (int a = 0; a < NumAxes; a++) begin
        filt_q[a]    <= '0;
        zero_q[a]    <= ZERO_RESET;
        quiet_q[a]   <= '0;
        settled_q[a] <= 1'b1;
      end
    end else begin
      if (cmd_i.cal_mul) begin
        cal_q <= cal_d;
        for (int a = 0; a < NumAxes; a++) begin
          zero_q[a]    <= zero_d[a];
          quiet_q[a]   <= quiet_d[a];
          settled_q[a] <= settled_d[a];
        end
      end
      if (cmd_i.acc) begin
        for (int a = 0; a < NumAxes; a++) begin
          filt_q[a] <= filt_d[a];
        end
      end
      if (cmd_i.num) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q[0] <= pitch_sample_i;
      sample_q[1] <= roll_sample_i;
      el_q        <= elapsed_ms_i;
      begin_q     <= begin_calibration_i;
    end
    for (int a = 0; a < NumAxes; a++) begin
      if (cmd_i.cal_mul) begin
        p_new_q[a] <= $signed({1'b0, w_eff}) * diff[a];
        p_old_q[a] <= $signed({1'b0, w_rest}) * filt_q[a];
      end
      if (cmd_i.scale) begin
        scaled_q[a] <= WScaled'(f_mag[a]) * WScaled'(el_q);
        neg_q[a]    <= filt_q[a][WFilt-1];
      end
      if (cmd_i.out_load) begin
        step_q[a] <= step_d[a];
        bias_q[a] <= zero_q[a];
      end
    end
    if (cmd_i.out_load) begin
      cal_out_q <= cal_q;
    end
  end

  assign sts_o.div_last = (cnt_q == WDivCnt'(DivSteps - 1));

  assign pitch_step_o  = step_q[0];
  assign roll_step_o   = step_q[1];
  assign pitch_bias_o  = bias_q[0];
  assign roll_bias_o   = bias_q[1];
  assign calibrating_o = cal_out_q;

endmodule
`default_nettype wire

// ===== design/grfi_ctrl.sv =====
// Controller: sequences one item through the datapath and owns both handshakes.
`timescale 1ns / 1ps
`default_nettype none
module grfi_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output grfi_pkg::grfi_cmd_t       cmd_o,
  input  wire grfi_pkg::grfi_sts_t  sts_i
);
  import grfi_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_ACC   = 7'b0000100,
    S_SCALE = 7'b0001000,
    S_NUM   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } grfi_state_e;

  grfi_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.cal_mul = 1'b1;
        state_d       = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_NUM;
      end
      S_NUM: begin
        cmd_o.num = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== design/gyro_rate_filter_integrator_core.sv =====
// Top level of the two-axis gyro rate filter and angle-step integrator.
//
// Usage: an item on the slave stream carries one raw pitch and one raw roll
// ADC reading and the milliseconds since the previous item; tuser asks for
// bias calibration to start before the item is processed. For every item the
// master stream returns one result: the pitch and roll angle steps in 2^-20
// rad (saturated), both bias levels in tenths of a count, and in tuser the
// flag that calibration is still running.
// Timing: an item is taken only while the block is idle; after acceptance it
// passes through calibration and filter products, accumulate, scaling, the
// reciprocal estimate of the quotient and its remainder check, and the
// output register load. The next item is taken only after that load.
// The output register lets the next item be accepted while a result waits;
// if the receiver stalls, the following result waits in the controller until
// the register frees, and no further item is taken meanwhile.
// Reset (asynchronous, active low) clears filter state, sets both biases to
// 2580 tenths, marks both axes settled and loads the register defaults.
// Registers are to be written through the APB port only while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module gyro_rate_filter_integrator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream. tdata: pitch_sample[9:0], roll_sample[19:10],
  // elapsed_ms[29:20], zero fill [31:30]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  // tuser: begin_calibration
  input  wire logic        s_axis_tuser,
  // Master stream. tdata: pitch_step[26:0], roll_step[53:27],
  // pitch_bias[67:54], roll_bias[81:68], zero fill [87:82]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,
  // tuser: calibrating
  output logic             m_axis_tuser,
  // Register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import grfi_pkg::*;

  logic [WWeight-1:0] filter_weight_q;
  logic [WSettle-1:0] settle_ms_q;
  logic               reg_wr;
  logic               reg_sel;

  grfi_cmd_t cmd;
  grfi_sts_t sts;

  logic [WStep-1:0] pitch_step, roll_step;
  logic [WBias-1:0] pitch_bias, roll_bias;

  // Register file: registers sit at 4-byte spacing, so bit 2 picks one.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_weight_q <= WEIGHT_RESET;
      settle_ms_q     <= SETTLE_RESET;
    end else if (reg_wr) begin
      if (reg_sel == REG_FILTER_WEIGHT) begin
        filter_weight_q <= pwdata[WWeight-1:0];
      end else begin
        settle_ms_q <= pwdata[WSettle-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_SETTLE_MS) begin
      prdata = {{(32-WSettle){1'b0}}, settle_ms_q};
    end else begin
      prdata = {{(32-WWeight){1'b0}}, filter_weight_q};
    end
  end

  grfi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  grfi_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .filter_weight_i     (filter_weight_q),
    .settle_ms_i         (settle_ms_q),
    .pitch_sample_i      (s_axis_tdata[9:0]),
    .roll_sample_i       (s_axis_tdata[19:10]),
    .elapsed_ms_i        (s_axis_tdata[29:20]),
    .begin_calibration_i (s_axis_tuser),
    .pitch_step_o        (pitch_step),
    .roll_step_o         (roll_step),
    .pitch_bias_o        (pitch_bias),
    .roll_bias_o         (roll_bias),
    .calibrating_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b000000, roll_bias, pitch_bias, roll_step, pitch_step};

endmodule
`default_nettype wire

// ===== design/grfi_checker.sv =====
// Port-level checker for the gyro rate filter core and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module grfi_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // One item at a time: taking an item closes the input side.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready stayed high after an item was taken");

  // A result cannot appear in the cycle right after its item was taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind gyro_rate_filter_integrator_core grfi_checker u_grfi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== test/gyro_rate_filter_integrator_core_tb.sv =====
// Self-checking testbench for the two-axis gyro rate filter and integrator.
`timescale 1ns / 1ps
module gyro_rate_filter_integrator_core_tb;
  import grfi_pkg::*;

  localparam int PITCH = 0;
  localparam int ROLL = 1;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles allowed after the last result before registers change.
  localparam int SETTLE_CYCLES = 25;

  // One sample item as the sender sees it.
  typedef struct {
    logic [WSample-1:0]  pitch;
    logic [WSample-1:0]  roll;
    logic [WElapsed-1:0] elapsed;
    logic                cal_start;
  } sample_item_t;

  // Master tdata layout, lowest field last.
  typedef struct packed {
    logic [5:0]              fill;
    logic [WBias-1:0]        roll_bias;
    logic [WBias-1:0]        pitch_bias;
    logic signed [WStep-1:0] roll_step;
    logic signed [WStep-1:0] pitch_step;
  } rate_word_t;

  typedef struct {
    rate_word_t word;
    logic       calibrating;
  } gyro_result_t;

  // Per-axis state of the behavioural copy of the block.
  typedef struct {
    int               filt;
    logic [WBias-1:0] zero;
    logic             settled;
    int               quiet;
  } axis_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gyro_rate_filter_integrator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sample_item_t     queued_samples[$];
  gyro_result_t     pending_results[$];
  sample_item_t     next_sample;
  axis_state_t      gyro_axis[2];
  logic             cal_running;
  logic [WWeight-1:0] filter_weight_cfg;
  logic [WSettle-1:0] settle_ms_cfg;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               error_count;
  int               idle_cycles;

  // ---------------------------------------------------------------------
  // Behavioural copy of the block
  // ---------------------------------------------------------------------

  // Division rounded half away from zero; den is positive.
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Runs the IIR on one axis and returns its angle step in 2^-20 rad.
  function automatic longint filter_axis(int ax, int diff, int elapsed);
    longint w;
    longint acc;
    longint f;
    longint s;
    w = (filter_weight_cfg > WEIGHT_FULL) ? longint'(WEIGHT_FULL)
                                          : longint'(filter_weight_cfg);
    acc = w * diff * 256 + (256 - w) * longint'(gyro_axis[ax].filt);
    f = clamp_to(round_div(acc, 256), -8388608, 8388607);
    gyro_axis[ax].filt = int'(f);
    s = round_div(f * elapsed * longint'(STEP_NUM), longint'(STEP_DEN));
    return clamp_to(s, -67108864, 67108863);
  endfunction

  // One calibration step: nudge the bias toward the reading, or count quiet
  // time while the reading matches the bias exactly. The start item adds no time.
  function automatic void calibrate_axis(int ax, int diff, int elapsed, logic fresh);
    int q;
    if (gyro_axis[ax].settled)
      return;
    if (diff > 0) begin
      gyro_axis[ax].zero = gyro_axis[ax].zero + 1'b1;
      gyro_axis[ax].quiet = 0;
    end else if (diff < 0) begin
      gyro_axis[ax].zero = gyro_axis[ax].zero - 1'b1;
      gyro_axis[ax].quiet = 0;
    end else begin
      if (!fresh) begin
        q = gyro_axis[ax].quiet + elapsed;
        gyro_axis[ax].quiet = (q > int'(QUIET_MAX)) ? int'(QUIET_MAX) : q;
      end
      if (gyro_axis[ax].quiet >= int'(settle_ms_cfg))
        gyro_axis[ax].settled = 1'b1;
    end
  endfunction

  function automatic gyro_result_t next_gyro_result(sample_item_t it);
    gyro_result_t r;
    int pd;
    int rd;
    longint ps;
    longint rs;
    if (it.cal_start) begin
      cal_running = 1'b1;
      for (int a = 0; a < 2; a++) begin
        gyro_axis[a].settled = 1'b0;
        gyro_axis[a].quiet = 0;
      end
    end
    // The filter sees the bias from before this item's nudge.
    pd = int'(it.pitch) * 10 - int'(gyro_axis[PITCH].zero);
    rd = int'(it.roll) * 10 - int'(gyro_axis[ROLL].zero);
    ps = filter_axis(PITCH, pd, int'(it.elapsed));
    rs = filter_axis(ROLL, rd, int'(it.elapsed));
    if (cal_running) begin
      calibrate_axis(PITCH, pd, int'(it.elapsed), it.cal_start);
      calibrate_axis(ROLL, rd, int'(it.elapsed), it.cal_start);
      if (gyro_axis[PITCH].settled && gyro_axis[ROLL].settled)
        cal_running = 1'b0;
    end
    r.word = '0;
    r.word.pitch_step = ps[WStep-1:0];
    r.word.roll_step = rs[WStep-1:0];
    r.word.pitch_bias = gyro_axis[PITCH].zero;
    r.word.roll_bias = gyro_axis[ROLL].zero;
    r.calibrating = cal_running;
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender: holds each item until it is taken, idles only between items.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (queued_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = queued_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, next_sample.elapsed, next_sample.roll,
                         next_sample.pitch};
        s_axis_tuser <= next_sample.cal_start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on every accepted item and checks every result.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    sample_item_t taken;
    gyro_result_t want;
    rate_word_t got;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      taken.pitch = s_axis_tdata[9:0];
      taken.roll = s_axis_tdata[19:10];
      taken.elapsed = s_axis_tdata[29:20];
      taken.cal_start = s_axis_tuser;
      pending_results.push_back(next_gyro_result(taken));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, got tdata %h", $time,
                 m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("pitch_step", $signed(want.word.pitch_step), $signed(got.pitch_step));
        check_field("roll_step", $signed(want.word.roll_step), $signed(got.roll_step));
        check_field("pitch_bias", want.word.pitch_bias, got.pitch_bias);
        check_field("roll_bias", want.word.roll_bias, got.roll_bias);
        check_field("calibrating", want.calibrating, m_axis_tuser);
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles in which nothing at all is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Sampled on the falling edge so that every update of the edge is seen.
  task automatic wait_drained();
    do
      @(negedge clk_i);
    while (queued_samples.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Registers only change once the block has gone quiet.
  task automatic write_config(input int weight, input int settle);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    reg_write({REG_FILTER_WEIGHT, 2'b00}, weight);
    reg_write({REG_SETTLE_MS, 2'b00}, settle);
    filter_weight_cfg = weight;
    settle_ms_cfg = settle;
  endtask

  task automatic queue_sample(input int p, input int r, input int el, input logic cal);
    sample_item_t it;
    it.pitch = p;
    it.roll = r;
    it.elapsed = el;
    it.cal_start = cal;
    queued_samples.push_back(it);
  endtask

  // A reading at or close to the present bias, so that calibration can settle.
  function automatic int reading_near(logic [WBias-1:0] zero);
    int v;
    v = int'(zero) / 10;
    if ($urandom_range(1) == 1)
      v = v + int'($urandom_range(4)) - 2;
    return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
  endfunction

  function automatic int pick_elapsed();
    int dice;
    dice = $urandom_range(99);
    if (dice < 60)
      return $urandom_range(80, 1);
    else if (dice < 85)
      return $urandom_range(1023);
    return 0;
  endfunction

  // Mostly calibration runs with steady readings near the bias, each started
  // from a drained block so the bias is known; the rest is raw noise.
  task automatic gen_random(input int count);
    int made;
    int len;
    int pr;
    int rr;
    made = 0;
    while (made < count) begin
      len = $urandom_range(30, 8);
      if ($urandom_range(99) < 70) begin
        wait_drained();
        pr = reading_near(gyro_axis[PITCH].zero);
        rr = reading_near(gyro_axis[ROLL].zero);
        for (int k = 0; k < len && made < count; k++) begin
          queue_sample(($urandom_range(99) < 8) ? int'($urandom_range(1023)) : pr,
                       ($urandom_range(99) < 8) ? int'($urandom_range(1023)) : rr,
                       pick_elapsed(), (k == 0) || ($urandom_range(99) < 3));
          made++;
        end
      end else begin
        for (int k = 0; k < len && made < count; k++) begin
          queue_sample($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                       $urandom_range(99) < 5);
          made++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    error_count = 0;
    idle_cycles = 0;
    send_idle_pct = 35;
    recv_idle_pct = 66;
    filter_weight_cfg = WEIGHT_RESET;
    settle_ms_cfg = SETTLE_RESET;
    cal_running = 1'b0;
    for (int a = 0; a < 2; a++) begin
      gyro_axis[a].filt = 0;
      gyro_axis[a].zero = ZERO_RESET;
      gyro_axis[a].settled = 1'b1;
      gyro_axis[a].quiet = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes with the reset bias of 2580 tenths.
    queue_sample(0, 0, 0, 1'b0);
    queue_sample(1023, 1023, 1023, 1'b0);
    queue_sample(0, 1023, 1023, 1'b0);
    queue_sample(1023, 0, 512, 1'b0);
    queue_sample(258, 258, 1, 1'b0);
    // Calibration start on a reading equal to the bias: the start item counts no time.
    queue_sample(258, 258, 700, 1'b1);
    queue_sample(258, 258, 60, 1'b0);
    queue_sample(258, 258, 60, 1'b0);
    // Nonzero readings move the biases apart, then a restart mid-run.
    queue_sample(259, 257, 5, 1'b1);
    queue_sample(259, 257, 5, 1'b0);
    queue_sample(259, 257, 5, 1'b1);
    for (int k = 0; k < 8; k++)
      queue_sample(258, 258, 40, 1'b0);
    gen_random(130);

    // Full weight and instant settling; then swap the idling of both sides.
    write_config(WEIGHT_FULL, 0);
    send_idle_pct = 66;
    recv_idle_pct = 35;
    queue_sample(reading_near(gyro_axis[PITCH].zero), reading_near(gyro_axis[ROLL].zero),
                 3, 1'b1);
    gen_random(110);

    // A frozen filter and the longest settle time.
    write_config(0, 1023);
    gen_random(70);

    // Weight above full scale, then the smallest nonzero weight, no idling.
    write_config(511, 37);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_random(70);
    write_config(1, 5);
    gen_random(60);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
